FILE: rtl/gb5_pkg.sv
package gb5_pkg;

  // Frame geometry limits and derived counter widths.
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int KERNEL_SIZE = 5;
  localparam int HALF_K      = KERNEL_SIZE / 2;
  localparam int LINES       = KERNEL_SIZE - 1;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int EW          = COL_W + 1;
  localparam int LAG_W       = COL_W + 2;
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int FW_W        = 12;
  localparam int FH_W        = 13;

  // Pixel and arithmetic widths.
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int TAP_W      = 3;
  localparam int COLSUM_W   = CH_W + 4;
  localparam int SUM_W      = COLSUM_W + 4;
  localparam int NORM_SHIFT = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [FW_W-1:0]      RESET_WIDTH      = 12'd640;
  localparam logic [FH_W-1:0]      RESET_HEIGHT     = 13'd480;

  // Item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // One-dimensional binomial taps; the 5x5 kernel is their outer product.
  localparam logic [TAP_W-1:0] GAUSS_TAP [KERNEL_SIZE] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_last;
  } blur_out_t;

endpackage

FILE: rtl/gaussian_blur_5x5_rgb_top.sv
// A result item moves from the window stage through the column-sum stage to the output
// register after the edge that accepts the item causing it.
// Throughput: one item per clock while pix_stall is low. A frame of at most 2*W+2 pixels
// adds 2*W+2-H*W dummy pushes, with input held off, to advance the line stores before its
// first flush item is taken. Reset (rst, synchronous): counters and valids clear, width 640,
// height 480; the line store memory is not cleared and needs no clearing pass.
module gaussian_blur_5x5_rgb_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  gb5_pkg::pix_in_t                 pix,
  output logic                             blur_valid,
  input  logic                             blur_stall,
  output gb5_pkg::blur_out_t               blur,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int K      = gb5_pkg::KERNEL_SIZE;
  localparam int COL_W  = gb5_pkg::COL_W;
  localparam int EW     = gb5_pkg::EW;
  localparam int LAG_W  = gb5_pkg::LAG_W;
  localparam int ROW_W  = gb5_pkg::ROW_W;
  localparam int FW_W   = gb5_pkg::FW_W;
  localparam int FH_W   = gb5_pkg::FH_W;
  localparam int PIX_W  = gb5_pkg::PIX_W;
  localparam int CH_W   = gb5_pkg::CH_W;
  localparam int NCH    = gb5_pkg::NUM_CH;
  localparam int CS_W   = gb5_pkg::COLSUM_W;
  localparam int SUM_W  = gb5_pkg::SUM_W;
  localparam int LINES  = gb5_pkg::LINES;
  localparam int MEM_W  = LINES * PIX_W;
  localparam int NSH    = gb5_pkg::NORM_SHIFT;

  // Configuration registers and their clamped values.
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [EW-1:0]    eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [LAG_W-1:0] thr;

  // Frame position tracking. The line store advances on every push: a real pixel, or a
  // dummy pixel during the flush phase. lag counts pushes not yet matched by an output.
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             in_done;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [LAG_W-1:0] lag;
  logic [COL_W-1:0] ptr;
  logic [COL_W-1:0] ptr_next;
  logic             in_col_end;
  logic             in_row_end;
  logic             out_col_end;
  logic             out_row_end;

  // Handshake and step decode.
  logic cfg_wr;
  logic cfg_restart;
  logic accept;
  logic data_ok;
  logic pad_need;
  logic pad_go;
  logic push;
  logic emit;
  logic last;
  logic s1_free;
  logic adv_s2;
  logic adv_out;

  // Line store: four chained delay lines of W pixels sharing one address, kept as one
  // wide memory word. Lane i of the read word is the pixel pushed (i+1)*W pushes ago.
  logic [MEM_W-1:0] line_mem [gb5_pkg::MAX_WIDTH];
  logic [MEM_W-1:0] line_rd;
  logic [MEM_W-1:0] line_wdata;
  logic [COL_W-1:0] rd_addr;
  gb5_pkg::rgb_t    new_px;
  gb5_pkg::rgb_t    tap [K];

  // 5x5 window, win[j][k]: j is horizontal (0 is leftmost), k vertical (0 is lowest row).
  gb5_pkg::rgb_t win [K][K];
  logic [K-1:0]  row_ok;
  logic [K-1:0]  col_ok;
  logic          s1_valid;
  logic [K-1:0]  s1_row_ok;
  logic [K-1:0]  s1_col_ok;
  logic          s1_last;

  // Vertical sums per window column and channel.
  logic [CS_W-1:0] colsum_next [K][NCH];
  logic [CS_W-1:0] colsum      [K][NCH];
  logic            s2_valid;
  logic [K-1:0]    s2_col_ok;
  logic            s2_last;

  logic [SUM_W-1:0] hsum [NCH];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // Only a write to one of the size registers restarts the frame; other indexes are ignored.
  assign cfg_restart = cfg_wr & ((cfg_index == gb5_pkg::REG_FRAME_WIDTH) |
                                 (cfg_index == gb5_pkg::REG_FRAME_HEIGHT));

  // Out-of-range sizes are clamped: zero counts as one, too large counts as the maximum.
  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if (frame_width > gb5_pkg::MAX_WIDTH) begin
      eff_w = EW'(gb5_pkg::MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = FH_W'(1);
    end else if (frame_height > gb5_pkg::MAX_HEIGHT) begin
      eff_h = FH_W'(gb5_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  // An output needs the pixel two lines and two columns past it.
  assign thr = {eff_w, 1'b0} + LAG_W'(2);

  assign in_col_end  = (EW'(in_col) + EW'(1)) == eff_w;
  assign in_row_end  = (FH_W'(in_row) + FH_W'(1)) == eff_h;
  assign out_col_end = (EW'(out_col) + EW'(1)) == eff_w;
  assign out_row_end = (FH_W'(out_row) + FH_W'(1)) == eff_h;
  assign last        = out_col_end & out_row_end;
  assign ptr_next    = ((EW'(ptr) + EW'(1)) == eff_w) ? '0 : ptr + COL_W'(1);

  // The window can shift only when the output it holds is moving on.
  assign adv_out = ~blur_valid | ~blur_stall;
  assign adv_s2  = ~s2_valid | adv_out;
  assign s1_free = ~s1_valid | adv_s2;

  // In a small frame the flush phase begins before the line store has advanced far enough;
  // dummy pushes close that gap while input is held off.
  assign pad_need  = in_done & (lag < thr);
  assign pad_go    = pad_need & s1_free;
  assign pix_stall = ~s1_free | pad_need;
  assign accept    = pix_valid & ~pix_stall;

  // A pixel item after the frame is complete is treated as a flush step.
  assign data_ok = (pix.command == gb5_pkg::CMD_PIXEL) & ~in_done;
  assign push    = pad_go | (accept & (data_ok | in_done));
  assign emit    = accept & (in_done | (data_ok & (lag == thr)));

  always_comb begin
    if (data_ok) begin
      new_px = '{red: pix.in_red, green: pix.in_green, blue: pix.in_blue};
    end else begin
      new_px = '0;
    end
  end

  always_comb begin
    tap[0] = new_px;
    for (int k = 1; k < K; k++) begin
      tap[k] = line_rd[(k-1)*PIX_W +: PIX_W];
    end
  end

  assign line_wdata = {line_rd[(LINES-1)*PIX_W-1:0], new_px};

  // The read address runs one push ahead, so the read word is ready when the next push
  // comes. With a one-pixel line the address does not move and the new word is forwarded.
  assign rd_addr = push ? ptr_next : ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[ptr] <= line_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (rd_addr == ptr)) begin
      line_rd <= line_wdata;
    end else begin
      line_rd <= line_mem[rd_addr];
    end
  end

  // Tap masks for the output being issued. Taps outside the image are dropped.
  always_comb begin
    row_ok[0] = (FH_W'(out_row) + FH_W'(2)) < eff_h;
    row_ok[1] = (FH_W'(out_row) + FH_W'(1)) < eff_h;
    row_ok[2] = 1'b1;
    row_ok[3] = out_row >= ROW_W'(1);
    row_ok[4] = out_row >= ROW_W'(2);
    col_ok[0] = out_col >= COL_W'(2);
    col_ok[1] = out_col >= COL_W'(1);
    col_ok[2] = 1'b1;
    col_ok[3] = (EW'(out_col) + EW'(1)) < eff_w;
    col_ok[4] = (EW'(out_col) + EW'(2)) < eff_w;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gb5_pkg::RESET_WIDTH;
      frame_height <= gb5_pkg::RESET_HEIGHT;
      in_col       <= '0;
      in_row       <= '0;
      in_done      <= 1'b0;
      out_col      <= '0;
      out_row      <= '0;
      lag          <= '0;
      ptr          <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      blur_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          gb5_pkg::REG_FRAME_WIDTH: begin
            frame_width <= cfg_data[FW_W-1:0];
          end
          gb5_pkg::REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data[FH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cfg_restart) begin
        // A new size restarts the frame.
        in_col  <= '0;
        in_row  <= '0;
        in_done <= 1'b0;
        out_col <= '0;
        out_row <= '0;
        lag     <= '0;
        ptr     <= '0;
      end else begin
        if (push) begin
          ptr <= ptr_next;
        end
        if (accept && data_ok) begin
          if (in_col_end) begin
            in_col <= '0;
            if (in_row_end) begin
              in_row  <= '0;
              in_done <= 1'b1;
            end else begin
              in_row <= in_row + ROW_W'(1);
            end
          end else begin
            in_col <= in_col + COL_W'(1);
          end
        end
        if (pad_go || (accept && data_ok && !emit)) begin
          lag <= lag + LAG_W'(1);
        end
        if (emit) begin
          if (last) begin
            in_col  <= '0;
            in_row  <= '0;
            in_done <= 1'b0;
            out_col <= '0;
            out_row <= '0;
            lag     <= '0;
          end else if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end

      if (push) begin
        s1_valid <= emit;
      end else if (adv_s2) begin
        s1_valid <= 1'b0;
      end
      if (adv_s2) begin
        s2_valid <= s1_valid;
      end
      if (adv_out) begin
        blur_valid <= s2_valid;
      end
    end
  end

  // Column sums with vertical weights, rows outside the image left out.
  always_comb begin
    for (int j = 0; j < K; j++) begin
      for (int c = 0; c < NCH; c++) begin
        colsum_next[j][c] = '0;
        for (int k = 0; k < K; k++) begin
          if (s1_row_ok[k]) begin
            colsum_next[j][c] = colsum_next[j][c] +
                CS_W'(win[j][k][c*CH_W +: CH_W]) * CS_W'(gb5_pkg::GAUSS_TAP[k]);
          end
        end
      end
    end
  end

  // Horizontal weighting of the column sums.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      hsum[c] = '0;
      for (int j = 0; j < K; j++) begin
        if (s2_col_ok[j]) begin
          hsum[c] = hsum[c] + SUM_W'(colsum[j][c]) * SUM_W'(gb5_pkg::GAUSS_TAP[j]);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (push) begin
      for (int j = 0; j < K - 1; j++) begin
        win[j] <= win[j+1];
      end
      win[K-1]  <= tap;
      s1_row_ok <= row_ok;
      s1_col_ok <= col_ok;
      s1_last   <= last;
    end
    if (adv_s2) begin
      colsum    <= colsum_next;
      s2_col_ok <= s1_col_ok;
      s2_last   <= s1_last;
    end
    if (adv_out) begin
      // Channel 2 is red, 1 green, 0 blue in the packed pixel.
      blur.out_red    <= hsum[2][NSH +: CH_W];
      blur.out_green  <= hsum[1][NSH +: CH_W];
      blur.out_blue   <= hsum[0][NSH +: CH_W];
      blur.frame_last <= s2_last;
    end
  end

endmodule

FILE: verif/testbench.sv
module testbench;
  import gb5_pkg::*;

  // The stored lines of the prediction, indexed by (row mod STORE_ROWS, column).
  localparam int STORE_ROWS = 8;

  typedef enum logic [1:0] {ROW_REG, ROW_SILENT, ROW_TYPED, ROW_PREDICT} row_kind_e;
  typedef enum logic [1:0] {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_e;

  // One line of the directed plan: either a register write or an item. Item lines
  // say whether their result is typed in here or taken from the prediction.
  typedef struct packed {
    row_kind_e                kind;
    pix_in_t                  item;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    blur_out_t                typed;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  pix_in_t               pix = '0;
  logic                  blur_valid;
  logic                  blur_stall = 1'b0;
  blur_out_t             blur;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gaussian_blur_5x5_rgb_top u_top (.*);

  // Prediction state: frame registers, the stored lines and the read and write cursors.
  logic [FW_W-1:0] width_reg = 12'd640;
  logic [FH_W-1:0] height_reg = 13'd480;
  rgb_t            line_mem [STORE_ROWS * MAX_WIDTH];
  int unsigned     wr_col, wr_row, rd_col, rd_row, backlog;
  bit              frame_received;
  int unsigned     binomial_tap [5] = '{1, 4, 6, 4, 1};

  blur_out_t   blur_expect_q [$];
  blur_out_t   head;
  int unsigned fail_count = 0;
  int unsigned useful_items = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  plan_row_t   plan [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A run that hangs ends here.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Out-of-range sizes are clamped: zero counts as one, too large counts as the maximum.
  function automatic int unsigned frame_cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned frame_rows();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  task automatic restart_cursor();
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
    backlog = 0;
    frame_received = 1'b0;
  endtask

  // Weighted 5x5 sum around the read cursor, then the cursor moves on. Taps that fall
  // outside the frame are skipped and the sum is not rescaled, so borders get darker.
  task automatic blur_at_cursor(output blur_out_t px);
    int unsigned cols, rows, acc_r, acc_g, acc_b, wt;
    int          r, c;
    rgb_t        tap;
    bit          last;
    cols = frame_cols();
    rows = frame_rows();
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int dy = -2; dy <= 2; dy++) begin
      r = int'(rd_row) + dy;
      if (r >= 0 && r < int'(rows)) begin
        for (int dx = -2; dx <= 2; dx++) begin
          c = int'(rd_col) + dx;
          if (c >= 0 && c < int'(cols)) begin
            tap = line_mem[(r % STORE_ROWS) * MAX_WIDTH + c];
            wt = binomial_tap[dy + 2] * binomial_tap[dx + 2];
            acc_r += wt * tap.red;
            acc_g += wt * tap.green;
            acc_b += wt * tap.blue;
          end
        end
      end
    end
    last = (rd_row + 1 == rows) && (rd_col + 1 == cols);
    px.out_red = CH_W'(acc_r >> 8);
    px.out_green = CH_W'(acc_g >> 8);
    px.out_blue = CH_W'(acc_b >> 8);
    px.frame_last = last;
    if (last) begin
      restart_cursor();
    end else begin
      rd_col++;
      if (rd_col >= cols) begin
        rd_col = 0;
        rd_row++;
      end
      if (backlog > 0) backlog--;
    end
  endtask

  // Works out what one accepted item does to the frame and whether it releases a pixel.
  // A data pixel after the whole frame is in is treated as a flush step.
  task automatic predict_item(input pix_in_t it, output bit got, output blur_out_t res);
    int unsigned cols, rows;
    cols = frame_cols();
    rows = frame_rows();
    got = 1'b0;
    res = '0;
    if (it.command == CMD_PIXEL && !frame_received) begin
      if (wr_col >= cols) wr_col = cols - 1;
      line_mem[(wr_row % STORE_ROWS) * MAX_WIDTH + wr_col] =
        {it.in_red, it.in_green, it.in_blue};
      wr_col++;
      if (wr_col >= cols) begin
        wr_col = 0;
        if (wr_row + 1 >= rows) begin
          wr_row = 0;
          frame_received = 1'b1;
        end else begin
          wr_row++;
        end
      end
      backlog++;
      if (backlog > 2 * cols + 2) begin
        blur_at_cursor(res);
        got = 1'b1;
      end
    end else if (frame_received) begin
      blur_at_cursor(res);
      got = 1'b1;
    end
  endtask

  function automatic logic [CH_W-1:0] pick_level();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  // Flush items carry random channel values too; the block has to ignore them.
  function automatic pix_in_t any_item(input logic cmd);
    return {cmd, pick_level(), pick_level(), pick_level()};
  endfunction

  function automatic plan_row_t item_row(input row_kind_e how, input logic cmd,
                                         input logic [PIX_W-1:0] rgb, input blur_out_t typed);
    return {how, cmd, rgb, {CFG_IDX_W{1'b0}}, {CFG_DATA_W{1'b0}}, typed};
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    return {ROW_REG, {($bits(pix_in_t)){1'b0}}, idx, val, {($bits(blur_out_t)){1'b0}}};
  endfunction

  // Register writes happen only with nothing in flight. The pause covers the block
  // stepping its line stores on its own after a short frame.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    pix_valid <= 1'b0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (2 * frame_cols() + 16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val[FW_W-1:0];
      restart_cursor();
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = val;
      restart_cursor();
    end
  endtask

  // Presents one item and holds it until taken. Valid is not dropped between
  // back-to-back items; it only goes low on an idle cycle.
  task automatic send_item(input pix_in_t it, input row_kind_e how, input blur_out_t typed);
    bit        got;
    blur_out_t guess;
    case (flow_e'((useful_items / 40) % 4))
      FLOW_FREE: begin
        sender_idle_pct = 0;
        sink_stall_pct = 0;
      end
      FLOW_SENDER_GAPS: begin
        sender_idle_pct = 73;
        sink_stall_pct = 0;
      end
      FLOW_SINK_STALLS: begin
        sender_idle_pct = 0;
        sink_stall_pct = 73;
      end
      default: begin
        sender_idle_pct = 34;
        sink_stall_pct = 34;
      end
    endcase
    while ($urandom_range(99) < sender_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix <= it;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    if (frame_received || it.command == CMD_PIXEL) useful_items++;
    predict_item(it, got, guess);
    if (how == ROW_TYPED) blur_expect_q.push_back(typed);
    else if (how == ROW_PREDICT && got) blur_expect_q.push_back(guess);
  endtask

  // One frame at the current size. Stray flushes land while the frame is still coming
  // in and must be ignored. A cut-short frame is abandoned and the next register write
  // throws away whatever it left pending.
  task automatic stream_frame(input bit cut_short);
    int unsigned pixels;
    pixels = frame_cols() * frame_rows();
    if (cut_short) pixels = $urandom_range(pixels - 1);
    repeat (pixels) begin
      if ($urandom_range(9) == 0) send_item(any_item(CMD_FLUSH), ROW_PREDICT, '0);
      send_item(any_item(CMD_PIXEL), ROW_PREDICT, '0);
    end
    if (!cut_short) begin
      while (frame_received) begin
        send_item(any_item($urandom_range(4) == 0 ? CMD_PIXEL : CMD_FLUSH), ROW_PREDICT, '0);
      end
    end
    repeat ($urandom_range(2)) send_item(any_item(CMD_FLUSH), ROW_PREDICT, '0);
  endtask

  // Mostly small sizes, sometimes zero (clamped to one) and sometimes a bit wider.
  function automatic int unsigned pick_span(input int unsigned top);
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(9, top);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // The result side stalls at random, at the rate of the current flow mode.
  always @(posedge clk) begin
    if (rst) blur_stall <= 1'b0;
    else blur_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Every taken result is matched against the oldest expected pixel.
  always @(posedge clk) begin
    if (!rst && blur_valid && !blur_stall) begin
      if (blur_expect_q.size() == 0) begin
        $error("blurred pixel %h arrived with none expected", blur);
        fail_count++;
      end else begin
        head = blur_expect_q.pop_front();
        if (blur.out_red !== head.out_red) begin
          $error("out_red: expected %0d, got %0d", head.out_red, blur.out_red);
          fail_count++;
        end
        if (blur.out_green !== head.out_green) begin
          $error("out_green: expected %0d, got %0d", head.out_green, blur.out_green);
          fail_count++;
        end
        if (blur.out_blue !== head.out_blue) begin
          $error("out_blue: expected %0d, got %0d", head.out_blue, blur.out_blue);
          fail_count++;
        end
        if (blur.frame_last !== head.frame_last) begin
          $error("frame_last: expected %0d, got %0d", head.frame_last, blur.frame_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned drain;
    restart_cursor();

    // Directed plan. A 1x1 frame keeps only the center tap (weight 36), so its
    // single output is the pixel times 36 over 256, flagged as the frame's last.
    plan.push_back(item_row(ROW_SILENT, CMD_FLUSH, 24'h000000, '0));   // flush before any pixel
    plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd0));                    // zero width means one
    plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd0));                   // zero height means one
    plan.push_back(item_row(ROW_SILENT, CMD_PIXEL, 24'hffffff, '0));
    plan.push_back(item_row(ROW_TYPED, CMD_FLUSH, 24'h000000, {8'd35, 8'd35, 8'd35, 1'b1}));
    plan.push_back(item_row(ROW_SILENT, CMD_FLUSH, 24'h000000, '0));   // nothing pending
    plan.push_back(item_row(ROW_SILENT, CMD_PIXEL, 24'h000000, '0));
    // A data pixel while the frame is complete only drains it; its data is dropped.
    plan.push_back(item_row(ROW_TYPED, CMD_PIXEL, 24'hffffff, {8'd0, 8'd0, 8'd0, 1'b1}));
    plan.push_back(item_row(ROW_SILENT, CMD_PIXEL, 24'hff0080, '0));
    plan.push_back(item_row(ROW_TYPED, CMD_FLUSH, 24'hffffff, {8'd35, 8'd0, 8'd18, 1'b1}));
    plan.push_back(reg_row(2'd2, 13'h1fff));                            // unknown index
    plan.push_back(reg_row(2'd3, 13'h0000));                            // unknown index
    plan.push_back(item_row(ROW_SILENT, CMD_PIXEL, 24'h808080, '0));
    plan.push_back(item_row(ROW_TYPED, CMD_FLUSH, 24'h000000, {8'd18, 8'd18, 8'd18, 1'b1}));
    plan.push_back(reg_row(REG_FRAME_WIDTH, 13'd3));
    plan.push_back(reg_row(REG_FRAME_HEIGHT, 13'd2));
    plan.push_back(item_row(ROW_PREDICT, CMD_PIXEL, 24'hffffff, '0));
    plan.push_back(item_row(ROW_PREDICT, CMD_PIXEL, 24'h000000, '0));
    plan.push_back(item_row(ROW_PREDICT, CMD_PIXEL, 24'hff00ff, '0));
    plan.push_back(item_row(ROW_PREDICT, CMD_PIXEL, 24'h00ff00, '0));
    plan.push_back(item_row(ROW_PREDICT, CMD_PIXEL, 24'h123456, '0));
    plan.push_back(item_row(ROW_PREDICT, CMD_PIXEL, 24'ha55ac3, '0));
    repeat (5) plan.push_back(item_row(ROW_PREDICT, CMD_FLUSH, 24'h000000, '0));
    plan.push_back(item_row(ROW_PREDICT, CMD_PIXEL, 24'hffffff, '0));
    plan.push_back(item_row(ROW_PREDICT, CMD_FLUSH, 24'h000000, '0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_item(plan[i].item, plan[i].kind, plan[i].typed);
    end

    // Random frames of small sizes; the width write sometimes sets the unused top bit.
    while (useful_items < 700) begin
      write_reg(REG_FRAME_WIDTH, {1'($urandom_range(1)), 12'(pick_span(40))});
      write_reg(REG_FRAME_HEIGHT, 13'(pick_span(10)));
      stream_frame($urandom_range(7) == 0);
    end

    // The largest sizes, each paired with a single line or column. Only the first
    // pixels of each frame are sent; the next register write drops the rest.
    write_reg(REG_FRAME_WIDTH, 13'($urandom_range(MAX_WIDTH, 4095)));
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    repeat (24) send_item(any_item(CMD_PIXEL), ROW_PREDICT, '0);
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(MAX_HEIGHT, 8191)));
    repeat (24) send_item(any_item(CMD_PIXEL), ROW_PREDICT, '0);

    pix_valid <= 1'b0;
    drain = 0;
    while (blur_expect_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (16) @(posedge clk);
    if (blur_expect_q.size() != 0) begin
      $error("%0d blurred pixels never arrived", blur_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
